// ===== rtl/tid_pkg.sv =====
// ----------------------------------------------------------------------------
// tid_pkg
// Shared types, codes and the fixed decode table for the tensor instruction
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tid_pkg;

  // instruction field widths
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OPCODE_W = 7;
  localparam int unsigned FUNCT3_W = 3;
  localparam int unsigned REG_W    = 5;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned UNIT_W   = 3;
  localparam int unsigned IMM_W    = 12;

  // upper bound on table slots that are searched
  localparam int unsigned MAX_SLOTS = 16;
  localparam int unsigned SLOT_W    = 4;

  // operation kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 4'd0,
    KIND_WMMA    = 4'd1,
    KIND_TLOAD   = 4'd2,
    KIND_TSTORE  = 4'd3,
    KIND_LOAD    = 4'd4,
    KIND_STORE   = 4'd5,
    KIND_BARRIER = 4'd6,
    KIND_SP      = 4'd7,
    KIND_INT     = 4'd8,
    KIND_DP      = 4'd9,
    KIND_SFU     = 4'd10
  } op_kind_t;

  // target units
  typedef enum logic [UNIT_W-1:0] {
    UNIT_NONE   = 3'd0,
    UNIT_TENSOR = 3'd1,
    UNIT_LSU    = 3'd2,
    UNIT_SYNC   = 3'd3,
    UNIT_SFU    = 3'd4
  } exec_unit_t;

  // opcodes of the default table
  localparam logic [OPCODE_W-1:0] OPC_WMMA   = 7'h21;
  localparam logic [OPCODE_W-1:0] OPC_TMEM   = 7'h23;
  localparam logic [OPCODE_W-1:0] OPC_TSTORE = 7'h27;
  localparam logic [OPCODE_W-1:0] OPC_LOAD   = 7'h03;
  localparam logic [OPCODE_W-1:0] OPC_SYNC   = 7'h33;
  localparam logic [OPCODE_W-1:0] OPC_SP     = 7'h43;
  localparam logic [OPCODE_W-1:0] OPC_INT    = 7'h53;
  localparam logic [OPCODE_W-1:0] OPC_DP     = 7'h63;
  localparam logic [OPCODE_W-1:0] OPC_SFU    = 7'h73;

  localparam logic [FUNCT3_W-1:0] F3_MASK_ALL = 3'b111;

  // one decode table entry
  typedef struct packed {
    exec_unit_t            unit;
    op_kind_t              kind;
    logic [FUNCT3_W-1:0]   mask;
    logic [FUNCT3_W-1:0]   funct3;
    logic [OPCODE_W-1:0]   opcode;
  } entry_t;

  // fixed table contents, slots past the defaults never match
  function automatic entry_t default_entry(input logic [SLOT_W-1:0] idx);
    entry_t e;
    e = '{unit: UNIT_NONE, kind: KIND_NONE, mask: F3_MASK_ALL, funct3: 3'd0,
          opcode: '0};
    unique case (idx)
      4'd0: e = '{UNIT_TENSOR, KIND_WMMA,    F3_MASK_ALL, 3'd1, OPC_WMMA};
      4'd1: e = '{UNIT_TENSOR, KIND_TLOAD,   F3_MASK_ALL, 3'd1, OPC_TMEM};
      4'd2: e = '{UNIT_TENSOR, KIND_TSTORE,  F3_MASK_ALL, 3'd1, OPC_TSTORE};
      4'd3: e = '{UNIT_LSU,    KIND_LOAD,    F3_MASK_ALL, 3'd2, OPC_LOAD};
      4'd4: e = '{UNIT_LSU,    KIND_STORE,   F3_MASK_ALL, 3'd2, OPC_TMEM};
      4'd5: e = '{UNIT_SYNC,   KIND_BARRIER, F3_MASK_ALL, 3'd1, OPC_SYNC};
      4'd6: e = '{UNIT_TENSOR, KIND_SP,      F3_MASK_ALL, 3'd1, OPC_SP};
      4'd7: e = '{UNIT_TENSOR, KIND_INT,     F3_MASK_ALL, 3'd0, OPC_INT};
      4'd8: e = '{UNIT_TENSOR, KIND_DP,      F3_MASK_ALL, 3'd1, OPC_DP};
      4'd9: e = '{UNIT_SFU,    KIND_SFU,     F3_MASK_ALL, 3'd1, OPC_SFU};
      default: e = '{UNIT_NONE, KIND_NONE, F3_MASK_ALL, 3'd0, 7'h00};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tid_in_if.sv =====
// ----------------------------------------------------------------------------
// tid_in_if
// Instruction channel: valid/ready handshake carrying one instruction word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tid_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/tid_out_if.sv =====
// ----------------------------------------------------------------------------
// tid_out_if
// Decode result channel: valid/ready handshake carrying one decoded
// instruction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tid_out_if;
  logic               valid;
  logic               ready;
  logic               matched;
  logic [3:0]         op_kind;
  logic [2:0]         exec_unit;
  logic               is_tensor;
  logic               is_memory;
  logic               is_barrier;
  logic [4:0]         dest_reg;
  logic [4:0]         src_reg_a;
  logic [4:0]         src_reg_b;
  logic [4:0]         src_reg_c;
  logic [4:0]         data_format;
  logic signed [11:0] immediate;

  modport source (
    output valid, input ready,
    output matched, output op_kind, output exec_unit, output is_tensor,
    output is_memory, output is_barrier, output dest_reg, output src_reg_a,
    output src_reg_b, output src_reg_c, output data_format, output immediate
  );
  modport sink (
    input valid, output ready,
    input matched, input op_kind, input exec_unit, input is_tensor,
    input is_memory, input is_barrier, input dest_reg, input src_reg_a,
    input src_reg_b, input src_reg_c, input data_format, input immediate
  );
endinterface

`default_nettype wire

// ===== rtl/tensor_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// tensor_instruction_decoder
// Three-stage decoder for a tensor-extended instruction set with a fixed
// priority decode table.
// ----------------------------------------------------------------------------
// Takes one instruction word per cycle while the output is taken. Its decode
// passes through the stage one, two and three registers on its way to the
// output. Stage one compares opcode and masked funct3 against every table
// slot in parallel, stage two picks the first matching slot, stage three
// derives flags, register fields and the signed immediate into the output
// register. Each stage carries its own valid bit and refills as soon as the
// next stage frees up, so a full pipeline keeps taking one word per cycle
// while the output is taken; a stalled output holds the output stage while
// earlier stages still fill any empty stage. Words that match no slot come
// out with matched, kind, unit, flags, accumulator, format and immediate zero.
`default_nettype none

module tensor_instruction_decoder
  import tid_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 10
) (
  input  wire        clk,
  input  wire        rst_n,
  tid_in_if.sink     in_chan,
  tid_out_if.source  out_chan
);

  // slots actually searched
  localparam int unsigned SLOTS = (TABLE_ENTRIES < MAX_SLOTS) ? TABLE_ENTRIES : MAX_SLOTS;

  // stage registers
  logic                 v1_r, v1_nxt;
  logic [WORD_W-1:0]    word1_r;
  logic [SLOTS-1:0]     hit1_r;
  logic [SLOTS-1:0]     hit_vec;

  logic                 v2_r, v2_nxt;
  logic [WORD_W-1:0]    word2_r;
  logic                 hit2_r;
  op_kind_t             kind2_r;
  exec_unit_t           unit2_r;
  logic                 hit_sel;
  op_kind_t             kind_sel;
  exec_unit_t           unit_sel;

  logic                 v3_r, v3_nxt;
  logic                 matched3_r;
  op_kind_t             kind3_r;
  exec_unit_t           unit3_r;
  logic                 tensor3_r, memory3_r, barrier3_r;
  logic [REG_W-1:0]     rd3_r, rs1_3_r, rs2_3_r, rs3_3_r, fmt3_r;
  logic [IMM_W-1:0]     imm3_r;
  logic [REG_W-1:0]     rs3_nxt, fmt_nxt;
  logic [IMM_W-1:0]     imm_nxt;

  logic                 rdy1, rdy2, rdy3;

  // stage advance: a stage loads when empty or when its contents move on
  assign rdy3 = !v3_r || out_chan.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_chan.ready = rdy1;

  assign v1_nxt = rdy1 ? in_chan.valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // stage 1: parallel compare against every slot
  always_comb begin
    entry_t e;
    logic [OPCODE_W-1:0] opc;
    logic [FUNCT3_W-1:0] f3;
    opc = in_chan.instruction_word[6:0];
    f3  = in_chan.instruction_word[14:12];
    for (int i = 0; i < SLOTS; i++) begin
      e = default_entry(SLOT_W'(i));
      hit_vec[i] = (e.kind != KIND_NONE) && (e.opcode == opc) &&
                   ((f3 & e.mask) == (e.funct3 & e.mask));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      word1_r <= in_chan.instruction_word;
      hit1_r  <= hit_vec;
    end
  end

  // stage 2: first matching slot wins
  always_comb begin
    entry_t e;
    hit_sel  = 1'b0;
    kind_sel = KIND_NONE;
    unit_sel = UNIT_NONE;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      e = default_entry(SLOT_W'(i));
      if (hit1_r[i]) begin
        hit_sel  = 1'b1;
        kind_sel = e.kind;
        unit_sel = e.unit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      word2_r <= word1_r;
      hit2_r  <= hit_sel;
      kind2_r <= kind_sel;
      unit2_r <= unit_sel;
    end
  end

  // stage 3: kind-dependent fields
  always_comb begin
    rs3_nxt = '0;
    fmt_nxt = '0;
    imm_nxt = '0;
    unique case (kind2_r)
      KIND_WMMA: begin
        rs3_nxt = word2_r[31:27];
        fmt_nxt = {3'b000, word2_r[26:25]};
      end
      KIND_TLOAD, KIND_LOAD: begin
        imm_nxt = word2_r[31:20];
      end
      KIND_TSTORE, KIND_STORE: begin
        imm_nxt = {word2_r[31:25], word2_r[11:7]};
      end
      KIND_SP, KIND_INT, KIND_DP: begin
        fmt_nxt = word2_r[24:20];
      end
      default: begin
        rs3_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      matched3_r <= hit2_r;
      kind3_r    <= kind2_r;
      unit3_r    <= unit2_r;
      tensor3_r  <= (unit2_r == UNIT_TENSOR) || (unit2_r == UNIT_SFU);
      memory3_r  <= (kind2_r == KIND_TLOAD) || (kind2_r == KIND_TSTORE) ||
                    (kind2_r == KIND_LOAD) || (kind2_r == KIND_STORE);
      barrier3_r <= (kind2_r == KIND_BARRIER);
      rd3_r      <= word2_r[11:7];
      rs1_3_r    <= word2_r[19:15];
      rs2_3_r    <= word2_r[24:20];
      rs3_3_r    <= rs3_nxt;
      fmt3_r     <= fmt_nxt;
      imm3_r     <= imm_nxt;
    end
  end

  // result transaction
  assign out_chan.valid       = v3_r;
  assign out_chan.matched     = matched3_r;
  assign out_chan.op_kind     = kind3_r;
  assign out_chan.exec_unit   = unit3_r;
  assign out_chan.is_tensor   = tensor3_r;
  assign out_chan.is_memory   = memory3_r;
  assign out_chan.is_barrier  = barrier3_r;
  assign out_chan.dest_reg    = rd3_r;
  assign out_chan.src_reg_a   = rs1_3_r;
  assign out_chan.src_reg_b   = rs2_3_r;
  assign out_chan.src_reg_c   = rs3_3_r;
  assign out_chan.data_format = fmt3_r;
  assign out_chan.immediate   = $signed(imm3_r);

  // unmatched words decode to all-zero control
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !matched3_r) |-> (kind3_r == KIND_NONE && unit3_r == UNIT_NONE &&
                               imm3_r == '0 && fmt3_r == '0))
    else $error("unmatched decode carries nonzero control");

  // a barrier always targets the sync unit
  a_barrier_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && barrier3_r) |-> (matched3_r && unit3_r == UNIT_SYNC))
    else $error("barrier decoded to wrong unit");

  // a stalled middle stage keeps its instruction
  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> (v2_r && $stable(word2_r) && $stable(kind2_r)))
    else $error("stage two lost its contents under stall");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!v1_r && !v2_r && !v3_r))
    else $error("valid bits set after reset");

endmodule

`default_nettype wire
